FILE: design/bwi_pkg.sv
`default_nettype none
package bwi_pkg;

  localparam int PRICE_W = 32;
  localparam int VAL_W   = 48;

  typedef enum logic [1:0] {
    MODE_RET_SHORT = 2'd0,
    MODE_RET_LONG  = 2'd1,
    MODE_ATR       = 2'd2,
    MODE_POS       = 2'd3
  } mode_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: design/bar_window_indicator.sv
// channel | signals                                              | direction
// in      | in_valid/in_ready, restart mode high_* low_* close_* | to block
// out     | out_valid/out_ready, stat_value stat_valid           | from block
// a request is taken, then the stored bars are walked one bar a cycle (all WINDOW bars; only one for returns)
// then a 64-step serial divider runs, and its quotient is registered into the result before out_valid rises
// in_ready is low until the result leaves, high the cycle after
// reset clears bar count and control; stored bars are not cleared
// a stalled output holds the result and blocks the next request
`default_nettype none
module bar_window_indicator #(
  parameter int WINDOW         = 20,
  parameter int SHORT_LOOKBACK = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        restart,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] high_price,
  input  wire logic        high_present,
  input  wire logic [31:0] low_price,
  input  wire logic        low_present,
  input  wire logic [31:0] close_price,
  input  wire logic        close_present,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [47:0] stat_value,
  output logic             stat_valid
);
  import bwi_pkg::*;

  localparam int DEPTH = ((SHORT_LOOKBACK > WINDOW) ? SHORT_LOOKBACK : WINDOW) + 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(WINDOW + 1);
  localparam int SW    = 32 + $clog2(WINDOW + 1) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_DIV  = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [31:0] cstore [DEPTH];
  logic        cknown [DEPTH];
  logic [31:0] hstore [WINDOW];
  logic [31:0] lstore [WINDOW];
  logic        rknown [WINDOW];
  logic [CW-1:0] bars;
  logic [1:0]  md;
  logic [IW-1:0] idx;
  logic [SW-1:0] sum;
  logic [31:0] lo, hi;
  logic        ok;
  logic        neg;
  logic [CW-1:0] bars_next;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [47:0] vout;

  // walk datapath: one bar per cycle
  logic [31:0] wh, wl, wpc;
  logic [33:0] tr, g1, g2, trm;
  logic signed [33:0] hl;
  assign wh  = hstore[idx[$clog2(WINDOW)-1:0]];
  assign wl  = lstore[idx[$clog2(WINDOW)-1:0]];
  assign wpc = cstore[CW'(idx) + CW'(1)];
  assign hl  = $signed({2'b0, wh}) - $signed({2'b0, wl});
  assign g1  = (wh >= wpc) ? {2'b0, wh - wpc} : {2'b0, wpc - wh};
  assign g2  = (wl >= wpc) ? {2'b0, wl - wpc} : {2'b0, wpc - wl};
  always_comb begin
    trm = (hl[33] || (g1 > 34'(hl))) ? g1 : 34'(hl);
    tr  = (g2 > trm) ? g2 : trm;
  end

  bwi_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    bars_next = restart ? '0 : bars;
    if (bars_next < CW'(DEPTH)) bars_next = bars_next + CW'(1);
  end

  // saturate quotient to 48-bit signed
  always_comb begin
    if (!neg) vout = (drsp.quotient > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF
                                                           : drsp.quotient[47:0];
    else if (drsp.quotient >= 64'h8000_0000_0000) vout = 48'h8000_0000_0000;
    else vout = 48'(0) - drsp.quotient[47:0];
  end

  always_ff @(posedge clk) begin
    dreq.start <= !rst && (state == S_DIV);
    if (in_valid && in_ready) begin
      for (int i = DEPTH - 1; i > 0; i--) begin
        cstore[i] <= cstore[i-1];
        cknown[i] <= cknown[i-1];
      end
      for (int i = WINDOW - 1; i > 0; i--) begin
        hstore[i] <= hstore[i-1];
        lstore[i] <= lstore[i-1];
        rknown[i] <= rknown[i-1];
      end
      cstore[0] <= close_price;
      cknown[0] <= close_present;
      hstore[0] <= high_price;
      lstore[0] <= low_price;
      rknown[0] <= high_present & low_present;
      md  <= mode;
      idx <= '0;
      sum <= '0;
      lo  <= low_price;
      hi  <= high_price;
      ok  <= 1'b1;
    end
    if (rst) begin
      state <= S_IDLE;
      bars  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          bars  <= bars_next;
          state <= S_WALK;
        end
        S_WALK: begin
          if (md == MODE_ATR || md == MODE_POS) begin
            if (!rknown[idx[$clog2(WINDOW)-1:0]]
                || (md == MODE_ATR && !cknown[CW'(idx) + CW'(1)])) ok <= 1'b0;
            sum <= sum + SW'(tr);
            if (wl < lo) lo <= wl;
            if (wh > hi) hi <= wh;
          end
          if (idx == IW'(WINDOW - 1) || md == MODE_RET_SHORT || md == MODE_RET_LONG)
            state <= S_DIV;
          else idx <= idx + IW'(1);
        end
        S_DIV: begin
          state <= S_WAIT;
          unique case (md)
            MODE_RET_SHORT, MODE_RET_LONG: begin
              logic [31:0] ce;
              ce = (md == MODE_RET_SHORT) ? cstore[SHORT_LOOKBACK] : cstore[WINDOW];
              neg <= cstore[0] < ce;
              dreq.dividend <= 64'((cstore[0] < ce) ? ce - cstore[0] : cstore[0] - ce)
                               * 64'd6553600;
              dreq.divisor  <= 64'(ce);
              ok <= (bars >= CW'(((md == MODE_RET_SHORT) ? SHORT_LOOKBACK : WINDOW) + 1))
                    && cknown[0]
                    && ((md == MODE_RET_SHORT) ? cknown[SHORT_LOOKBACK] : cknown[WINDOW])
                    && (ce != 32'd0);
            end
            MODE_ATR: begin
              neg <= 1'b0;
              dreq.dividend <= 64'(sum) * 64'd6553600;
              dreq.divisor  <= 64'(cstore[0]) * 64'(WINDOW);
              ok <= ok && (bars >= CW'(WINDOW + 1)) && cknown[0] && (cstore[0] != 32'd0);
            end
            default: begin
              neg <= cstore[0] < lo;
              dreq.dividend <= {16'd0, ((cstore[0] < lo) ? lo - cstore[0]
                                                         : cstore[0] - lo), 16'd0};
              dreq.divisor  <= 64'(hi - lo);
              ok <= ok && (bars >= CW'(WINDOW)) && cknown[0] && (hi > lo);
            end
          endcase
        end
        S_WAIT: if (drsp.done) begin
          stat_valid <= ok;
          stat_value <= ok ? $signed(vout) : '0;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stat_value)) else $error("result lost");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stat_valid |-> stat_value == '0) else $error("invalid nonzero");
  a_bars_bound: assert property (@(posedge clk) disable iff (rst)
    bars <= CW'(DEPTH)) else $error("bar count overflow");
`endif

endmodule
`default_nettype wire

FILE: design/bwi_divider.sv
`default_nettype none
module bwi_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  bwi_pkg::div_req_t      req,
  output bwi_pkg::div_rsp_t      rsp
);
  import bwi_pkg::*;

  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[63]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("done without busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy) else $error("start did not set busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("done held");
`endif

endmodule
`default_nettype wire

FILE: dv/bar_window_indicator_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module bar_window_indicator_tb;
  import bwi_pkg::*;

  localparam int WIN   = 20;
  localparam int SHORT = 5;
  localparam int DEPTH = WIN + 1;
  localparam logic [47:0] MAXPOS = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MINNEG = 48'h8000_0000_0000;

  typedef struct packed {
    logic        restart;
    mode_t       mode;
    logic [31:0] hi;
    logic        hi_p;
    logic [31:0] lo;
    logic        lo_p;
    logic [31:0] cl;
    logic        cl_p;
  } bar_t;

  typedef struct packed {
    logic        typed;
    logic [47:0] value;
    logic        valid;
  } stat_t;

  typedef struct packed {
    bar_t  bar;
    stat_t res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic restart = 0;
  logic [1:0] mode = 0;
  logic [31:0] high_price = 0, low_price = 0, close_price = 0;
  logic high_present = 0, low_present = 0, close_present = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [47:0] stat_value;
  logic stat_valid;

  bar_window_indicator #(.WINDOW(WIN), .SHORT_LOOKBACK(SHORT)) u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // history model
  logic [31:0] m_close[DEPTH];
  logic        m_close_k[DEPTH];
  logic [31:0] m_high[WIN];
  logic [31:0] m_low[WIN];
  logic        m_range_k[WIN];
  int          m_seen;

  stat_t pending_stats[$];
  int mismatches = 0;

  function automatic logic [47:0] sat48(logic [63:0] mag, bit neg);
    if (!neg) return (mag > 64'(MAXPOS)) ? MAXPOS : mag[47:0];
    if (mag >= 64'(MINNEG)) return MINNEG;
    return 48'(-mag);
  endfunction

  function automatic stat_t ret_pct(int lb);
    stat_t r;
    logic [63:0] c0, ce, d;
    bit neg;
    r = '0;
    if (m_seen < lb + 1 || !m_close_k[0] || !m_close_k[lb] || m_close[lb] == 0) return r;
    c0 = m_close[0];
    ce = m_close[lb];
    neg = c0 < ce;
    d = neg ? ce - c0 : c0 - ce;
    r.value = sat48(d * 64'd6553600 / ce, neg);
    r.valid = 1;
    return r;
  endfunction

  function automatic stat_t atr_pct();
    stat_t r;
    logic [63:0] sum, h, l, pc, tr, g;
    r = '0;
    sum = 0;
    if (m_seen < WIN + 1) return r;
    for (int a = 0; a < WIN; a++) begin
      if (!m_range_k[a] || !m_close_k[a+1]) return r;
      h = m_high[a];
      l = m_low[a];
      pc = m_close[a+1];
      tr = (h >= l) ? h - l : 0;
      g = (h >= pc) ? h - pc : pc - h;
      if (g > tr) tr = g;
      g = (l >= pc) ? l - pc : pc - l;
      if (g > tr) tr = g;
      sum += tr;
    end
    if (!m_close_k[0] || m_close[0] == 0) return r;
    r.value = sat48(sum * 64'd6553600 / (64'(WIN) * m_close[0]), 0);
    r.valid = 1;
    return r;
  endfunction

  function automatic stat_t range_pos();
    stat_t r;
    logic [31:0] lo, hi;
    logic [63:0] c, d;
    bit neg;
    r = '0;
    if (m_seen < WIN) return r;
    lo = m_low[0];
    hi = m_high[0];
    for (int a = 0; a < WIN; a++) begin
      if (!m_range_k[a]) return r;
      if (m_low[a] < lo) lo = m_low[a];
      if (m_high[a] > hi) hi = m_high[a];
    end
    if (!m_close_k[0] || hi <= lo) return r;
    c = m_close[0];
    neg = c < lo;
    d = neg ? 64'(lo) - c : c - lo;
    r.value = sat48(d * 64'd65536 / (64'(hi) - lo), neg);
    r.valid = 1;
    return r;
  endfunction

  function automatic stat_t push_bar(bar_t b);
    if (b.restart) m_seen = 0;
    for (int i = DEPTH - 1; i > 0; i--) begin
      m_close[i] = m_close[i-1];
      m_close_k[i] = m_close_k[i-1];
    end
    for (int i = WIN - 1; i > 0; i--) begin
      m_high[i] = m_high[i-1];
      m_low[i] = m_low[i-1];
      m_range_k[i] = m_range_k[i-1];
    end
    m_high[0] = b.hi;
    m_low[0] = b.lo;
    m_range_k[0] = b.hi_p && b.lo_p;
    m_close[0] = b.cl;
    m_close_k[0] = b.cl_p;
    if (m_seen < DEPTH) m_seen++;
    case (b.mode)
      MODE_RET_SHORT: return ret_pct(SHORT);
      MODE_RET_LONG:  return ret_pct(WIN);
      MODE_ATR:       return atr_pct();
      default:        return range_pos();
    endcase
  endfunction

  task automatic send_bar(bar_t b, stat_t typed_res);
    stat_t e;
    int gap;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    e = push_bar(b);
    if (typed_res.typed && (typed_res.value != e.value || typed_res.valid != e.valid))
      $display("directed row disagrees with predictor: %h/%0d vs %h/%0d",
               typed_res.value, typed_res.valid, e.value, e.valid);
    if (typed_res.typed) e = typed_res;
    pending_stats.push_back(e);
    in_valid <= 1;
    restart <= b.restart;
    mode <= b.mode;
    high_price <= b.hi;
    high_present <= b.hi_p;
    low_price <= b.lo;
    low_present <= b.lo_p;
    close_price <= b.cl;
    close_present <= b.cl_p;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic bar_t make_bar(bit rs, mode_t md, logic [31:0] h, logic [31:0] l,
                                    logic [31:0] c);
    bar_t b;
    b.restart = rs;
    b.mode = md;
    b.hi = h;
    b.lo = l;
    b.cl = c;
    b.hi_p = 1;
    b.lo_p = 1;
    b.cl_p = 1;
    return b;
  endfunction

  function automatic logic [31:0] near_price(logic [31:0] base);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom;
    if (k == 1) return $urandom_range(0, 3);
    return base + $urandom_range(0, 200) - 100;
  endfunction

  // output side
  always @(posedge clk) begin
    stat_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%0d", stat_value, stat_valid);
      end else begin
        e = pending_stats.pop_front();
        if (stat_value !== e.value || stat_valid !== e.valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%0d got %h/%0d",
                     e.value, e.valid, stat_value, stat_valid);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready) stall_left <= $urandom_range(0, 10);
    else if (stall_left > 0) stall_left <= stall_left - 1;
    out_ready <= (stall_left <= 1) && !(out_valid && out_ready && $urandom_range(0, 3) != 0);
  end

  row_t rows[$];

  initial begin
    bar_t b;
    stat_t none_typed, zero_typed;
    logic [31:0] base;
    int n;
    none_typed = '0;
    zero_typed = '{typed: 1, value: 0, valid: 0};
    m_seen = 0;
    for (int i = 0; i < DEPTH; i++) begin m_close[i] = 0; m_close_k[i] = 0; end
    for (int i = 0; i < WIN; i++) begin
      m_high[i] = 0; m_low[i] = 0; m_range_k[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: short history invalid for each mode right after reset
    rows.push_back('{make_bar(0, MODE_RET_SHORT, 100, 90, 95), zero_typed});
    rows.push_back('{make_bar(0, MODE_RET_LONG, 100, 90, 95), zero_typed});
    rows.push_back('{make_bar(0, MODE_ATR, 100, 90, 95), zero_typed});
    rows.push_back('{make_bar(0, MODE_POS, 100, 90, 95), zero_typed});
    // close of 1 then max close for short return saturation
    rows.push_back('{make_bar(1, MODE_RET_SHORT, 5, 0, 1), zero_typed});
    for (int i = 0; i < 4; i++)
      rows.push_back('{make_bar(0, MODE_POS, 32'hFFFF_FFFF, 0, 7), none_typed});
    rows.push_back('{make_bar(0, MODE_RET_SHORT, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF),
                     '{typed: 1, value: sat48(64'hFFFF_FFFE * 64'd6553600, 0), valid: 1}});
    rows.push_back('{make_bar(0, MODE_RET_LONG, 0, 32'hFFFF_FFFF, 0), zero_typed});
    for (int i = 0; i < 9; i++)
      rows.push_back('{make_bar(0, MODE_RET_SHORT, 32'hFFFF_FFFF, 0, i * 1000),
                       none_typed});
    rows.push_back('{make_bar(0, MODE_ATR, 10, 32'hFFFF_FFFF, 0), zero_typed});
    rows.push_back('{make_bar(0, MODE_ATR, 0, 32'hFFFF_FFFF, 1), none_typed});
    rows.push_back('{make_bar(0, MODE_POS, 50, 50, 50), none_typed});
    rows.push_back('{make_bar(0, MODE_RET_LONG, 50, 50, 3), none_typed});
    foreach (rows[i]) send_bar(rows[i].bar, rows[i].res);

    // random: mostly clean series with noise
    n = 0;
    base = 1000;
    while (n < 1250) begin
      b.restart = ($urandom_range(0, 60) == 0);
      if (b.restart) begin
        case ($urandom_range(0, 3))
          0: base = $urandom;
          1: base = $urandom_range(1, 50);
          default: base = $urandom_range(100, 100000);
        endcase
      end
      b.mode = mode_t'($urandom_range(0, 3));
      b.cl = near_price(base);
      base = b.cl;
      b.hi = b.cl + $urandom_range(0, 50);
      b.lo = b.cl - $urandom_range(0, 50);
      if ($urandom_range(0, 15) == 0) b.hi = $urandom;
      if ($urandom_range(0, 15) == 0) b.lo = $urandom;
      b.hi_p = $urandom_range(0, 40) != 0;
      b.lo_p = $urandom_range(0, 40) != 0;
      b.cl_p = $urandom_range(0, 40) != 0;
      send_bar(b, none_typed);
      n++;
      if (n == 600) begin
        in_valid <= 0;
        wait (pending_stats.size() == 0);
      end
    end
    in_valid <= 0;
    wait (pending_stats.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
